/* rtl/accumulator_alu_with_flags_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the accumulator ALU
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_ALU_WITH_FLAGS_ASSERT_SVH
`define ACCUMULATOR_ALU_WITH_FLAGS_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define AAF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define AAF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/acc_alu_pkg.sv */
// ----------------------------------------------------------------------------
// Accumulator ALU package
// Operation codes, flag positions and the single-pass evaluation function.
// ----------------------------------------------------------------------------
package acc_alu_pkg;

   localparam int unsigned OPCODE_WIDTH = 5;
   localparam int unsigned DATA_WIDTH   = 8;
   localparam int unsigned FLAGS_WIDTH  = 4;

   typedef logic [OPCODE_WIDTH-1:0] opcode_type;
   typedef logic [DATA_WIDTH-1:0]   data_type;
   typedef logic [FLAGS_WIDTH-1:0]  flags_type;

   localparam opcode_type OP_ADD  = 5'd0;
   localparam opcode_type OP_ADC  = 5'd1;
   localparam opcode_type OP_SUB  = 5'd2;
   localparam opcode_type OP_SBC  = 5'd3;
   localparam opcode_type OP_AND  = 5'd4;
   localparam opcode_type OP_XOR  = 5'd5;
   localparam opcode_type OP_OR   = 5'd6;
   localparam opcode_type OP_CP   = 5'd7;
   localparam opcode_type OP_INC  = 5'd8;
   localparam opcode_type OP_DEC  = 5'd9;
   localparam opcode_type OP_RLCA = 5'd10;
   localparam opcode_type OP_RRCA = 5'd11;
   localparam opcode_type OP_RLA  = 5'd12;
   localparam opcode_type OP_RRA  = 5'd13;
   localparam opcode_type OP_DAA  = 5'd14;
   localparam opcode_type OP_CPL  = 5'd15;
   localparam opcode_type OP_SCF  = 5'd16;
   localparam opcode_type OP_CCF  = 5'd17;

   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_H = 1;
   localparam int unsigned FLAG_C = 0;

   localparam data_type DAA_LIMIT   = 8'h99;
   localparam data_type DAA_ADJ_HI  = 8'h60;
   localparam data_type DAA_ADJ_LO  = 8'h06;
   localparam data_type SIGN_BIT    = 8'h80;
   localparam logic [3:0] DIGIT_MAX = 4'h9;

   typedef struct packed {
      data_type  result;
      logic      result_write;
      flags_type flags;
   } alu_word_type;

   function automatic alu_word_type alu_eval(input opcode_type op, input data_type a,
                                             input data_type b, input flags_type f);
      alu_word_type o;
      logic         c;
      logic         t;
      logic [8:0]   sum;
      logic [4:0]   half;
      data_type     adj;
      logic         daa_hi;
      logic         daa_lo;
      c            = f[FLAG_C];
      t            = 1'b0;
      sum          = '0;
      half         = '0;
      adj          = '0;
      daa_hi       = 1'b0;
      daa_lo       = 1'b0;
      o.result       = a;
      o.result_write = 1'b1;
      o.flags        = f;
      case (op)
         OP_ADD, OP_ADC: begin
            t    = (op == OP_ADC) ? c : 1'b0;
            sum  = {1'b0, a} + {1'b0, b} + {8'd0, t};
            half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
            o.result = sum[7:0];
            o.flags  = {sum[7:0] == 8'd0, 1'b0, half[4], sum[8]};
         end
         OP_SUB, OP_SBC, OP_CP: begin
            t    = (op == OP_SBC) ? c : 1'b0;
            sum  = {1'b0, a} - {1'b0, b} - {8'd0, t};
            half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
            o.result = sum[7:0];
            o.flags  = {sum[7:0] == 8'd0, 1'b1, half[4], sum[8]};
            if (op == OP_CP) begin
               o.result       = a;
               o.result_write = 1'b0;
            end
         end
         OP_AND: begin
            o.result = a & b;
            o.flags  = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
         end
         OP_XOR: begin
            o.result = a ^ b;
            o.flags  = {(a ^ b) == 8'd0, 3'b000};
         end
         OP_OR: begin
            o.result = a | b;
            o.flags  = {(a | b) == 8'd0, 3'b000};
         end
         OP_INC: begin
            o.result = b + 8'd1;
            o.flags  = {b == 8'hFF, 1'b0, b[3:0] == 4'hF, c};
         end
         OP_DEC: begin
            o.result = b - 8'd1;
            o.flags  = {b == 8'h01, 1'b1, b[3:0] == 4'h0, c};
         end
         OP_RLCA: begin
            o.result = {a[6:0], a[7]};
            o.flags  = {3'b000, a[7]};
         end
         OP_RRCA: begin
            o.result = {a[0], a[7:1]};
            o.flags  = {3'b000, a[0]};
         end
         OP_RLA: begin
            o.result = {a[6:0], c};
            o.flags  = {3'b000, a[7]};
         end
         OP_RRA: begin
            o.result = {c, a[7:1]};
            o.flags  = {3'b000, a[0]};
         end
         OP_DAA: begin
            if (!f[FLAG_N]) begin
               daa_hi = c || (a > DAA_LIMIT);
               daa_lo = f[FLAG_H] || (a[3:0] > DIGIT_MAX);
            end else begin
               daa_hi = c;
               daa_lo = f[FLAG_H];
            end
            adj = (daa_hi ? DAA_ADJ_HI : 8'd0) | (daa_lo ? DAA_ADJ_LO : 8'd0);
            o.result = f[FLAG_N] ? (a - adj) : (a + adj);
            o.flags  = {o.result == 8'd0, f[FLAG_N], 1'b0,
                        f[FLAG_N] ? c : (c || daa_hi)};
         end
         OP_CPL: begin
            o.result = ~a;
            o.flags  = {f[FLAG_Z], 1'b1, 1'b1, c};
         end
         OP_SCF: begin
            o.result_write = 1'b0;
            o.flags        = {f[FLAG_Z], 3'b001};
         end
         OP_CCF: begin
            o.result_write = 1'b0;
            o.flags        = {f[FLAG_Z], 2'b00, ~c};
         end
         default: begin
            o.result_write = 1'b0;
         end
      endcase
      return o;
   endfunction

endpackage

/* rtl/accumulator_alu_with_flags.sv */
// ----------------------------------------------------------------------------
// Accumulator ALU with flags
// Eight-bit accumulator ALU with Z, N, H and C flags, pipelined in two stages.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (opcode, accumulator, operand, flags) is taken on the req_
//   channel at each clock edge where req_valid is high and req_stall is low.
//   One response word (result byte, write enable, new flags) leaves on the
//   rsp_ channel for every request, in order.
//   The request is held in an input register; the ALU logic sits between that
//   register and the response register, so each word passes through the
//   input register and then the response register, which drives rsp_valid.
//   Throughput is one word per cycle while rsp_stall is low, set by the single
//   pass through the ALU logic.
//   While the receiver stalls, the response register holds its word and the
//   input register can still take one more request; req_stall rises only when
//   both registers are full and the response is stalled.
//   Synchronous reset empties both registers; the block keeps no other state.
// ----------------------------------------------------------------------------
`include "accumulator_alu_with_flags_assert.svh"

module accumulator_alu_with_flags (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  acc_alu_pkg::opcode_type   req_opcode,
   input  acc_alu_pkg::data_type     req_acc_in,
   input  acc_alu_pkg::data_type     req_operand,
   input  acc_alu_pkg::flags_type    req_flags_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output acc_alu_pkg::data_type     rsp_result,
   output logic                      rsp_result_write,
   output acc_alu_pkg::flags_type    rsp_flags_out
);
   import acc_alu_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   opcode_type   s1_opcode_ff;
   data_type     s1_acc_ff;
   data_type     s1_operand_ff;
   flags_type    s1_flags_ff;
   logic         out_valid_ff, out_valid_in;
   alu_word_type out_word_ff;
   alu_word_type alu_word;
   logic         out_advance;
   logic         s1_load;

   assign out_advance = !out_valid_ff || !rsp_stall;
   assign s1_load     = req_valid && !req_stall;
   assign req_stall   = s1_valid_ff && !out_advance;

   assign alu_word = alu_eval(s1_opcode_ff, s1_acc_ff, s1_operand_ff, s1_flags_ff);

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_advance) begin
         out_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_opcode_ff  <= req_opcode;
         s1_acc_ff     <= req_acc_in;
         s1_operand_ff <= req_operand;
         s1_flags_ff   <= req_flags_in;
      end
      if (out_advance && s1_valid_ff) begin
         out_word_ff <= alu_word;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result       = out_word_ff.result;
   assign rsp_result_write = out_word_ff.result_write;
   assign rsp_flags_out    = out_word_ff.flags;

   `AAF_ASSERT_NEXT(a_accept_fills_s1, s1_load, s1_valid_ff,
      "accepted word did not reach the input register")
   `AAF_ASSERT_NEXT(a_s1_moves_out, s1_valid_ff && out_advance,
      rsp_valid && rsp_result == $past(alu_word.result)
      && rsp_flags_out == $past(alu_word.flags),
      "response register did not take the ALU word")
   `AAF_ASSERT_NEXT(a_no_write_back, s1_valid_ff && out_advance
      && (s1_opcode_ff == OP_CP || s1_opcode_ff == OP_SCF || s1_opcode_ff == OP_CCF),
      !rsp_result_write, "compare or carry operation requested a write back")
   `AAF_ASSERT_SAME(a_stall_only_full, req_stall,
      s1_valid_ff && out_valid_ff && rsp_stall, "request stalled with room in the pipeline")

endmodule
